// File: src/power_good_sequencer_unit_defines.svh
// Assertion helpers for the power good sequencer
`ifndef POWER_GOOD_SEQUENCER_UNIT_DEFINES_SVH
`define POWER_GOOD_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PGS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define PGS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/pgs_pkg.sv
package pgs_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int THR_BITS        = 10;
	localparam int RUN_BITS        = 4;
	localparam int WIN_BITS        = 7;
	localparam int ACTION_BITS     = 2;
	localparam int EVENT_BITS      = 3;
	localparam int APB_ADDR_BITS   = 5;
	localparam int APB_DATA_BITS   = 32;
	localparam int REG_IDX_BITS    = 3;

	// action codes
	localparam logic [ACTION_BITS-1:0] ACT_TICK = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_ON   = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_OFF  = 2'd2;

	// event codes
	localparam logic [EVENT_BITS-1:0] EV_NONE    = 3'd0;
	localparam logic [EVENT_BITS-1:0] EV_GOOD    = 3'd1;
	localparam logic [EVENT_BITS-1:0] EV_RISE_TO = 3'd2;
	localparam logic [EVENT_BITS-1:0] EV_LOST    = 3'd3;
	localparam logic [EVENT_BITS-1:0] EV_FALL_OK = 3'd4;
	localparam logic [EVENT_BITS-1:0] EV_FALL_TO = 3'd5;

	// register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_PRESENT = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_ON      = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_OFF     = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_CONFIRM = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_RISE_WIN = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_FALL_WIN = 3'd5;

	// register reset values
	localparam logic [THR_BITS-1:0] PRESENT_RST = 10'd50;
	localparam logic [THR_BITS-1:0] ON_RST      = 10'd400;
	localparam logic [THR_BITS-1:0] OFF_RST     = 10'd40;
	localparam logic [RUN_BITS-1:0] CONFIRM_RST = 4'd6;
	localparam logic [WIN_BITS-1:0] RISE_WIN_RST = 7'd50;
	localparam logic [WIN_BITS-1:0] FALL_WIN_RST = 7'd100;

endpackage

// File: src/pgs_in_if.sv
interface pgs_in_if #(
	parameter int SAMPLE_BITS = pgs_pkg::SAMPLE_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic [pgs_pkg::ACTION_BITS-1:0]    action;
	logic [SAMPLE_BITS-1:0]             sample;

	modport source (output valid, output action, output sample, input ready);
	modport sink (input valid, input action, input sample, output ready);
endinterface

// File: src/pgs_out_if.sv
interface pgs_out_if;
	logic                              valid;
	logic                              ready;
	logic                              enable_out;
	logic                              powered;
	logic                              indicator;
	logic                              busy_res;
	logic [pgs_pkg::EVENT_BITS-1:0]    event_res;

	modport source (output valid, output enable_out, output powered, output indicator,
		output busy_res, output event_res, input ready);
	modport sink (input valid, input enable_out, input powered, input indicator,
		input busy_res, input event_res, output ready);
endinterface

// File: src/power_good_sequencer_unit.sv
// Each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while the sink is ready. Sequencer state
// updates as each item leaves the input register; consecutive items see each other's
// effect in order; the result register frees once taken, so stalls cost no bubbles.
// Reset (arst_n low, asynchronous): idle, flags and enable low, registers to defaults.
`include "power_good_sequencer_unit_defines.svh"

module power_good_sequencer_unit #(
	parameter int SAMPLE_BITS = pgs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	pgs_in_if.sink                             inp,
	pgs_out_if.source                          res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pgs_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [pgs_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [pgs_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready
);

	localparam int CMP_BITS = (SAMPLE_BITS > pgs_pkg::THR_BITS) ? SAMPLE_BITS
		: pgs_pkg::THR_BITS;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_WATCH = 2'd1;
	localparam logic [1:0] MODE_RISE  = 2'd2;
	localparam logic [1:0] MODE_FALL  = 2'd3;

	localparam logic [pgs_pkg::RUN_BITS-1:0] RUN_MAX = '1;

	// configuration registers
	logic [pgs_pkg::THR_BITS-1:0]  present_thr_q, on_thr_q, off_thr_q;
	logic [pgs_pkg::RUN_BITS-1:0]  confirm_q;
	logic [pgs_pkg::WIN_BITS-1:0]  rise_win_q, fall_win_q;

	// sequencer state
	logic [1:0]                    mode_q;
	logic [pgs_pkg::RUN_BITS-1:0]  high_run_q;
	logic [pgs_pkg::WIN_BITS-1:0]  samples_left_q;
	logic                          power_q, enable_q, lamp_q;

	// input stage
	logic                             valid_s1;
	logic [pgs_pkg::ACTION_BITS-1:0]  action_s1;
	logic [SAMPLE_BITS-1:0]           sample_s1;

	// result register
	logic                             res_valid_q;
	logic                             res_enable_q, res_powered_q, res_lamp_q, res_busy_q;
	logic [pgs_pkg::EVENT_BITS-1:0]   res_event_q;

	logic advance;
	logic cfg_wr;
	logic [pgs_pkg::REG_IDX_BITS-1:0] reg_idx;

	logic [CMP_BITS-1:0]    present_ext, on_ext, off_ext;
	logic [SAMPLE_BITS-1:0] present_s, on_s, off_s;

	logic [1:0]                    mode_d;
	logic [pgs_pkg::RUN_BITS-1:0]  high_run_d, run_inc;
	logic [pgs_pkg::WIN_BITS-1:0]  samples_left_d;
	logic                          power_d, enable_d, lamp_d;
	logic [pgs_pkg::EVENT_BITS-1:0] event_d;
	logic                          is_high, confirmed, spent;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign inp.ready = !valid_s1 || advance;

	assign res.valid      = res_valid_q;
	assign res.enable_out = res_enable_q;
	assign res.powered    = res_powered_q;
	assign res.indicator  = res_lamp_q;
	assign res.busy_res   = res_busy_q;
	assign res.event_res  = res_event_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[pgs_pkg::APB_ADDR_BITS-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (reg_idx)
			pgs_pkg::REG_PRESENT:  prdata = pgs_pkg::APB_DATA_BITS'(present_thr_q);
			pgs_pkg::REG_ON:       prdata = pgs_pkg::APB_DATA_BITS'(on_thr_q);
			pgs_pkg::REG_OFF:      prdata = pgs_pkg::APB_DATA_BITS'(off_thr_q);
			pgs_pkg::REG_CONFIRM:  prdata = pgs_pkg::APB_DATA_BITS'(confirm_q);
			pgs_pkg::REG_RISE_WIN: prdata = pgs_pkg::APB_DATA_BITS'(rise_win_q);
			pgs_pkg::REG_FALL_WIN: prdata = pgs_pkg::APB_DATA_BITS'(fall_win_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_thr_q <= pgs_pkg::PRESENT_RST;
			on_thr_q      <= pgs_pkg::ON_RST;
			off_thr_q     <= pgs_pkg::OFF_RST;
			confirm_q     <= pgs_pkg::CONFIRM_RST;
			rise_win_q    <= pgs_pkg::RISE_WIN_RST;
			fall_win_q    <= pgs_pkg::FALL_WIN_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				pgs_pkg::REG_PRESENT:  present_thr_q <= pwdata[pgs_pkg::THR_BITS-1:0];
				pgs_pkg::REG_ON:       on_thr_q      <= pwdata[pgs_pkg::THR_BITS-1:0];
				pgs_pkg::REG_OFF:      off_thr_q     <= pwdata[pgs_pkg::THR_BITS-1:0];
				pgs_pkg::REG_CONFIRM:  confirm_q     <= pwdata[pgs_pkg::RUN_BITS-1:0];
				pgs_pkg::REG_RISE_WIN: rise_win_q    <= pwdata[pgs_pkg::WIN_BITS-1:0];
				pgs_pkg::REG_FALL_WIN: fall_win_q    <= pwdata[pgs_pkg::WIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// fit thresholds to the sample width
	assign present_ext = CMP_BITS'(present_thr_q);
	assign on_ext      = CMP_BITS'(on_thr_q);
	assign off_ext     = CMP_BITS'(off_thr_q);
	assign present_s   = present_ext[SAMPLE_BITS-1:0];
	assign on_s        = on_ext[SAMPLE_BITS-1:0];
	assign off_s       = off_ext[SAMPLE_BITS-1:0];

	always_comb begin
		mode_d         = mode_q;
		high_run_d     = high_run_q;
		samples_left_d = samples_left_q;
		power_d        = power_q;
		enable_d       = enable_q;
		lamp_d         = lamp_q;
		event_d        = pgs_pkg::EV_NONE;

		// commands restart any running sequence
		if (action_s1 == pgs_pkg::ACT_ON) begin
			enable_d       = 1'b1;
			mode_d         = MODE_RISE;
			high_run_d     = '0;
			samples_left_d = rise_win_q;
		end else if (action_s1 == pgs_pkg::ACT_OFF) begin
			enable_d       = 1'b0;
			mode_d         = MODE_FALL;
			high_run_d     = '0;
			samples_left_d = fall_win_q;
		end else if (mode_q == MODE_IDLE) begin
			if (sample_s1 <= present_s) begin
				if (power_q)
					event_d = pgs_pkg::EV_LOST;
				power_d = 1'b0;
				lamp_d  = 1'b0;
			end else if (!power_q) begin
				mode_d         = MODE_WATCH;
				high_run_d     = '0;
				samples_left_d = rise_win_q;
			end
		end

		is_high   = (mode_d == MODE_WATCH) ? (sample_s1 > present_s) : (sample_s1 > on_s);
		run_inc   = (high_run_d < RUN_MAX) ? high_run_d + 1'b1 : high_run_d;
		confirmed = is_high && (run_inc >= confirm_q);
		spent     = (samples_left_d <= pgs_pkg::WIN_BITS'(1));

		case (mode_d)
			MODE_WATCH, MODE_RISE: begin
				high_run_d = is_high ? run_inc : '0;
				if (confirmed) begin
					power_d = 1'b1;
					if (mode_d == MODE_WATCH)
						lamp_d = 1'b1;
					event_d = pgs_pkg::EV_GOOD;
					mode_d  = MODE_IDLE;
				end else begin
					samples_left_d = spent ? '0 : samples_left_d - 1'b1;
					if (spent) begin
						if (mode_d == MODE_WATCH) begin
							power_d = 1'b0;
							lamp_d  = 1'b0;
						end
						event_d = pgs_pkg::EV_RISE_TO;
						mode_d  = MODE_IDLE;
					end
				end
			end
			MODE_FALL: begin
				if (sample_s1 < off_s) begin
					power_d        = 1'b0;
					event_d        = pgs_pkg::EV_FALL_OK;
					mode_d         = MODE_IDLE;
					samples_left_d = '0;
				end else begin
					samples_left_d = spent ? '0 : samples_left_d - 1'b1;
					if (spent) begin
						event_d = pgs_pkg::EV_FALL_TO;
						mode_d  = MODE_IDLE;
					end
				end
			end
			default: ;
		endcase

		if (mode_d == MODE_IDLE)
			high_run_d = '0;
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (inp.ready) begin
			valid_s1 <= inp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (inp.ready && inp.valid) begin
			action_s1 <= inp.action;
			sample_s1 <= inp.sample;
		end
	end

	// sequencer state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			high_run_q     <= '0;
			samples_left_q <= '0;
			power_q        <= 1'b0;
			enable_q       <= 1'b0;
			lamp_q         <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				mode_q         <= mode_d;
				high_run_q     <= high_run_d;
				samples_left_q <= samples_left_d;
				power_q        <= power_d;
				enable_q       <= enable_d;
				lamp_q         <= lamp_d;
				res_valid_q    <= 1'b1;
			end else if (res.ready) begin
				res_valid_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_enable_q  <= enable_d;
			res_powered_q <= power_d;
			res_lamp_q    <= lamp_d;
			res_busy_q    <= (mode_d != MODE_IDLE);
			res_event_q   <= event_d;
		end
	end

	`PGS_ASSERT_NOW(a_idle_run_clear, mode_q == MODE_IDLE, high_run_q == '0, "run count left in idle")
	`PGS_ASSERT_NOW(a_watch_unpowered, mode_q == MODE_WATCH, !power_q, "watch window while powered")
	`PGS_ASSERT_NEXT(a_good_sets_flag, advance && event_d == pgs_pkg::EV_GOOD, res_powered_q && power_q, "confirm without power flag")
	`PGS_ASSERT_NEXT(a_fall_ok_off, advance && event_d == pgs_pkg::EV_FALL_OK, !res_powered_q && !res_enable_q, "fall confirmed with supply on")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import pgs_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam logic [ACTION_BITS-1:0] ACT_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int NUM_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int SMP_MAX = (1 << SB) - 1;

	typedef enum logic [2:0] {SEQ_IDLE, SEQ_WATCH, SEQ_RISE, SEQ_FALL} seq_mode_t;
	typedef enum logic [1:0] {QUAL_WAIT, QUAL_CONFIRM, QUAL_TIMEOUT} qual_t;
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic                  enable_out;
		logic                  powered;
		logic                  indicator;
		logic                  busy;
		logic [EVENT_BITS-1:0] ev;
	} pgs_status_t;

	typedef struct {
		row_kind_t               kind;
		logic [ACTION_BITS-1:0]  act;
		logic [SB-1:0]           smp;
		logic [REG_IDX_BITS-1:0] idx;
		logic [APB_DATA_BITS-1:0] val;
		bit                      has_exp;
		pgs_status_t             exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	pgs_in_if #(.SAMPLE_BITS(SB)) inp_if();
	pgs_out_if res_if();

	power_good_sequencer_unit #(.SAMPLE_BITS(SB)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.inp     (inp_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow configuration and sequencer state
	logic [THR_BITS-1:0] cfg_present, cfg_on, cfg_off;
	logic [RUN_BITS-1:0] cfg_confirm;
	logic [WIN_BITS-1:0] cfg_rise_win, cfg_fall_win;
	seq_mode_t           sup_mode;
	logic [RUN_BITS-1:0] run_cnt;
	logic [WIN_BITS-1:0] win_left;
	logic                pg_flag, en_flag, lamp_flag;

	pgs_status_t expected_status[$];
	stim_row_t   dir_rows[$];
	int          errors = 0;
	int          cycle_cnt = 0;
	bit          hold_req = 1'b0;
	bit          no_gap = 1'b0;

	function automatic bit window_spent();
		if (win_left <= 1) begin
			win_left = '0;
			return 1'b1;
		end
		win_left = win_left - 1'b1;
		return 1'b0;
	endfunction

	function automatic qual_t qualify_sample(bit high);
		if (high) begin
			if (run_cnt < 4'd15)
				run_cnt = run_cnt + 1'b1;
			if (run_cnt >= cfg_confirm)
				return QUAL_CONFIRM;
		end else begin
			run_cnt = '0;
		end
		return window_spent() ? QUAL_TIMEOUT : QUAL_WAIT;
	endfunction

	function automatic pgs_status_t sequence_step(logic [ACTION_BITS-1:0] act,
			logic [SB-1:0] smp);
		logic [EVENT_BITS-1:0] ev;
		qual_t q;
		pgs_status_t st;
		ev = EV_NONE;
		if (act == ACT_ON) begin
			en_flag = 1'b1;
			sup_mode = SEQ_RISE;
			run_cnt = '0;
			win_left = cfg_rise_win;
		end else if (act == ACT_OFF) begin
			en_flag = 1'b0;
			sup_mode = SEQ_FALL;
			run_cnt = '0;
			win_left = cfg_fall_win;
		end else if (sup_mode == SEQ_IDLE) begin
			if (smp <= cfg_present) begin
				if (pg_flag)
					ev = EV_LOST;
				pg_flag = 1'b0;
				lamp_flag = 1'b0;
			end else if (!pg_flag) begin
				sup_mode = SEQ_WATCH;
				run_cnt = '0;
				win_left = cfg_rise_win;
			end
		end

		case (sup_mode)
			SEQ_WATCH: begin
				q = qualify_sample(smp > cfg_present);
				if (q == QUAL_CONFIRM) begin
					pg_flag = 1'b1;
					lamp_flag = 1'b1;
					ev = EV_GOOD;
					sup_mode = SEQ_IDLE;
				end else if (q == QUAL_TIMEOUT) begin
					pg_flag = 1'b0;
					lamp_flag = 1'b0;
					ev = EV_RISE_TO;
					sup_mode = SEQ_IDLE;
				end
			end
			SEQ_RISE: begin
				// lamp is left alone on a commanded rise
				q = qualify_sample(smp > cfg_on);
				if (q == QUAL_CONFIRM) begin
					pg_flag = 1'b1;
					ev = EV_GOOD;
					sup_mode = SEQ_IDLE;
				end else if (q == QUAL_TIMEOUT) begin
					ev = EV_RISE_TO;
					sup_mode = SEQ_IDLE;
				end
			end
			SEQ_FALL: begin
				if (smp < cfg_off) begin
					pg_flag = 1'b0;
					ev = EV_FALL_OK;
					sup_mode = SEQ_IDLE;
					win_left = '0;
				end else if (window_spent()) begin
					ev = EV_FALL_TO;
					sup_mode = SEQ_IDLE;
				end
			end
			default: ;
		endcase

		if (sup_mode == SEQ_IDLE)
			run_cnt = '0;

		st.enable_out = en_flag;
		st.powered = pg_flag;
		st.indicator = lamp_flag;
		st.busy = (sup_mode != SEQ_IDLE);
		st.ev = ev;
		return st;
	endfunction

	function automatic pgs_status_t mk_status(bit e, bit p, bit i, bit b,
			logic [EVENT_BITS-1:0] ev);
		pgs_status_t st;
		st = '{enable_out: e, powered: p, indicator: i, busy: b, ev: ev};
		return st;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [SB-1:0] above(logic [THR_BITS-1:0] thr);
		if (int'(thr) >= SMP_MAX)
			return SMP_MAX[SB-1:0];
		return SB'($urandom_range(SMP_MAX, int'(thr) + 1));
	endfunction

	function automatic logic [SB-1:0] below(logic [THR_BITS-1:0] thr);
		if (thr == 0)
			return '0;
		return SB'($urandom_range(int'(thr) - 1, 0));
	endfunction

	function automatic logic [ACTION_BITS-1:0] tick_code();
		return ($urandom_range(19, 0) == 0) ? ACT_SPARE : ACT_TICK;
	endfunction

	task automatic check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	task automatic send_item(logic [ACTION_BITS-1:0] act, logic [SB-1:0] smp,
			bit has_exp, pgs_status_t exp_typed);
		int gap;
		pgs_status_t st;
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			inp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		inp_if.valid <= 1'b1;
		inp_if.action <= act;
		inp_if.sample <= smp;
		@(posedge clk);
		while (!inp_if.ready)
			@(posedge clk);
		st = sequence_step(act, smp);
		expected_status.push_back(has_exp ? exp_typed : st);
	endtask

	task automatic send(logic [ACTION_BITS-1:0] act, logic [SB-1:0] smp);
		send_item(act, smp, 1'b0, '0);
	endtask

	task automatic wait_idle();
		inp_if.valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [REG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// leave the bus idle between transfers
		@(posedge clk);
		case (idx)
			REG_PRESENT:  cfg_present = val[THR_BITS-1:0];
			REG_ON:       cfg_on = val[THR_BITS-1:0];
			REG_OFF:      cfg_off = val[THR_BITS-1:0];
			REG_CONFIRM:  cfg_confirm = val[RUN_BITS-1:0];
			REG_RISE_WIN: cfg_rise_win = val[WIN_BITS-1:0];
			REG_FALL_WIN: cfg_fall_win = val[WIN_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic add_row(logic [ACTION_BITS-1:0] act, logic [SB-1:0] smp);
		dir_rows.push_back('{ROW_ITEM, act, smp, '0, '0, 1'b0, '0});
	endtask

	task automatic add_chk(logic [ACTION_BITS-1:0] act, logic [SB-1:0] smp,
			pgs_status_t exp);
		dir_rows.push_back('{ROW_ITEM, act, smp, '0, '0, 1'b1, exp});
	endtask

	task automatic add_cfg(logic [REG_IDX_BITS-1:0] idx, int val);
		dir_rows.push_back('{ROW_CFG, ACT_TICK, '0, idx, val, 1'b0, '0});
	endtask

	function automatic int pick_thr();
		int r;
		r = $urandom_range(9, 0);
		if (r == 0)
			return 0;
		if (r == 1)
			return SMP_MAX;
		return $urandom_range(SMP_MAX, 0);
	endfunction

	function automatic int pick_win();
		int r;
		r = $urandom_range(19, 0);
		if (r == 0)
			return 0;
		if (r == 1)
			return 127;
		if (r < 5)
			return $urandom_range(127, 1);
		return $urandom_range(20, 1);
	endfunction

	task automatic random_config();
		int c;
		reg_write(REG_PRESENT, pick_thr());
		reg_write(REG_ON, pick_thr());
		reg_write(REG_OFF, pick_thr());
		c = $urandom_range(19, 0);
		if (c == 0)
			c = 0;
		else if (c == 1)
			c = 15;
		else
			c = $urandom_range(7, 1);
		reg_write(REG_CONFIRM, c);
		reg_write(REG_RISE_WIN, pick_win());
		reg_write(REG_FALL_WIN, pick_win());
	endtask

	// one well-formed random sequence, noise, or near-threshold samples
	task automatic send_burst(output int n);
		int kind, len, i, d, v, t;
		logic [SB-1:0] s;
		kind = $urandom_range(9, 0);
		len = $urandom_range(int'(cfg_confirm) + 4, 1);
		n = 0;
		case (kind)
			0, 1, 2: begin
				send(ACT_ON, above(cfg_on));
				n++;
				for (i = 0; i < len; i++) begin
					s = ($urandom_range(99, 0) < 85) ? above(cfg_on)
						: SB'($urandom_range(int'(cfg_on), 0));
					send(tick_code(), s);
					n++;
				end
			end
			3, 4: begin
				send(ACT_OFF, SB'($urandom_range(SMP_MAX, int'(cfg_off))));
				n++;
				for (i = 0; i < len; i++) begin
					s = (i == len - 1 && $urandom_range(1, 0)) ? below(cfg_off)
						: SB'($urandom_range(SMP_MAX, int'(cfg_off)));
					send(tick_code(), s);
					n++;
				end
			end
			5, 6, 7: begin
				for (i = 0; i < len; i++) begin
					s = ($urandom_range(99, 0) < 90) ? above(cfg_present)
						: SB'($urandom_range(int'(cfg_present), 0));
					send(tick_code(), s);
					n++;
				end
				if ($urandom_range(1, 0)) begin
					send(ACT_TICK, SB'($urandom_range(int'(cfg_present), 0)));
					n++;
				end
			end
			8: begin
				for (i = 0; i < len; i++) begin
					send(ACTION_BITS'($urandom_range(3, 0)), SB'($urandom_range(SMP_MAX, 0)));
					n++;
				end
			end
			default: begin
				case ($urandom_range(2, 0))
					0: t = int'(cfg_present);
					1: t = int'(cfg_on);
					default: t = int'(cfg_off);
				endcase
				for (d = -1; d <= 1; d++) begin
					v = t + d;
					if (v < 0)
						v = 0;
					if (v > SMP_MAX)
						v = SMP_MAX;
					case ($urandom_range(5, 0))
						0: send(ACT_ON, SB'(v));
						1: send(ACT_OFF, SB'(v));
						default: send(ACT_TICK, SB'(v));
					endcase
					n++;
				end
			end
		endcase
	endtask

	// stimulus and configuration
	initial begin
		int ph, sent, n, k;
		stim_row_t row;

		arst_n = 1'b0;
		inp_if.valid = 1'b0;
		inp_if.action = ACT_TICK;
		inp_if.sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		cfg_present = PRESENT_RST;
		cfg_on = ON_RST;
		cfg_off = OFF_RST;
		cfg_confirm = CONFIRM_RST;
		cfg_rise_win = RISE_WIN_RST;
		cfg_fall_win = FALL_WIN_RST;
		sup_mode = SEQ_IDLE;
		run_cnt = '0;
		win_left = '0;
		pg_flag = 1'b0;
		en_flag = 1'b0;
		lamp_flag = 1'b0;

		// defaults: monitor qualification, loss, commanded rise and fall
		add_chk(ACT_TICK, 10'd0, mk_status(1'b0, 1'b0, 1'b0, 1'b0, EV_NONE));
		add_row(ACT_TICK, 10'd1023);
		add_row(ACT_TICK, 10'd1023);
		add_row(ACT_TICK, 10'd1023);
		add_row(ACT_TICK, 10'd1023);
		add_row(ACT_TICK, 10'd1023);
		add_chk(ACT_TICK, 10'd1023, mk_status(1'b0, 1'b1, 1'b1, 1'b0, EV_GOOD));
		add_chk(ACT_TICK, 10'd50, mk_status(1'b0, 1'b0, 1'b0, 1'b0, EV_LOST));
		add_row(ACT_ON, 10'd401);
		add_row(ACT_TICK, 10'd400);
		add_row(ACT_SPARE, 10'd1023);
		add_row(ACT_ON, 10'd1023);
		add_row(ACT_OFF, 10'd40);
		add_chk(ACT_TICK, 10'd39, mk_status(1'b0, 1'b0, 1'b0, 1'b0, EV_FALL_OK));
		add_chk(ACT_OFF, 10'd0, mk_status(1'b0, 1'b0, 1'b0, 1'b0, EV_FALL_OK));
		// zero confirm count and zero windows, thresholds at the extremes
		add_cfg(REG_CONFIRM, 0);
		add_cfg(REG_RISE_WIN, 0);
		add_cfg(REG_FALL_WIN, 0);
		add_cfg(REG_PRESENT, SMP_MAX);
		add_cfg(REG_ON, 0);
		add_cfg(REG_OFF, SMP_MAX);
		add_chk(ACT_TICK, 10'd1023, mk_status(1'b0, 1'b0, 1'b0, 1'b0, EV_NONE));
		add_chk(ACT_ON, 10'd0, mk_status(1'b1, 1'b0, 1'b0, 1'b0, EV_RISE_TO));
		add_chk(ACT_ON, 10'd1, mk_status(1'b1, 1'b1, 1'b0, 1'b0, EV_GOOD));
		add_chk(ACT_OFF, 10'd1023, mk_status(1'b0, 1'b1, 1'b0, 1'b0, EV_FALL_TO));
		add_chk(ACT_OFF, 10'd1022, mk_status(1'b0, 1'b0, 1'b0, 1'b0, EV_FALL_OK));
		add_cfg(REG_PRESENT, 0);
		add_cfg(REG_CONFIRM, 15);
		add_cfg(REG_RISE_WIN, 127);
		add_cfg(REG_FALL_WIN, 127);
		add_cfg(REG_OFF, 0);
		add_cfg(REG_ON, SMP_MAX);
		add_row(ACT_TICK, 10'd1);
		add_row(ACT_ON, 10'd1023);
		add_row(ACT_OFF, 10'd0);
		add_row(ACT_TICK, 10'd0);
		add_row(ACT_TICK, 10'd512);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < dir_rows.size(); k++) begin
			row = dir_rows[k];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				reg_write(row.idx, row.val);
			end else begin
				send_item(row.act, row.smp, row.has_exp, row.exp);
			end
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			random_config();
			// back up the block once while items keep coming
			if (ph == 3)
				hold_req = 1'b1;
			no_gap = (ph == 3) || ($urandom_range(3, 0) == 0);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				send_burst(n);
				sent += n;
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		if (errors == 0)
			$display("power_good_sequencer_unit: match");
		else
			$display("power_good_sequencer_unit: mismatch");
		$finish;
	end

	// result sink: random stalls plus one long hold
	initial begin
		int hold_left, run_left, stall_left;
		bit level;
		hold_left = 0;
		run_left = 0;
		stall_left = 0;
		res_if.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				level = 1'b0;
			end else if (run_left > 0) begin
				run_left--;
				level = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				level = 1'b0;
			end else begin
				run_left = $urandom_range(39, 0);
				stall_left = pick_gap();
				level = 1'b1;
			end
			res_if.ready <= level;
			@(posedge clk);
		end
	end

	pgs_status_t got_status, want_status;

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_status.size() == 0) begin
				$error("result transaction with no pending expectation");
				errors++;
			end else begin
				want_status = expected_status.pop_front();
				got_status = mk_status(res_if.enable_out, res_if.powered, res_if.indicator,
					res_if.busy_res, res_if.event_res);
				check_field("enable_out", int'(want_status.enable_out),
					int'(got_status.enable_out));
				check_field("powered", int'(want_status.powered), int'(got_status.powered));
				check_field("indicator", int'(want_status.indicator),
					int'(got_status.indicator));
				check_field("busy_res", int'(want_status.busy), int'(got_status.busy));
				check_field("event_res", int'(want_status.ev), int'(got_status.ev));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("power_good_sequencer_unit: mismatch");
			$finish;
		end
	end

endmodule

// File: files.f
+incdir+src
src/pgs_pkg.sv
src/pgs_in_if.sv
src/pgs_out_if.sv
src/power_good_sequencer_unit.sv
tb/tb_top.sv
